FILE: hdl/hygienic_fork_exchange_node_top_macros.svh
// Assertion macros used by the checker of this block.
`ifndef HYGIENIC_FORK_EXCHANGE_NODE_TOP_MACROS_SVH
`define HYGIENIC_FORK_EXCHANGE_NODE_TOP_MACROS_SVH

// Property checked only outside reset.
`define HFEN_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("hfen assertion failed");

// Property checked at every edge, reset included.
`define HFEN_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("hfen assertion failed");

`endif

FILE: hdl/hfen_pkg.sv
package hfen_pkg;

  // Event kinds on the input stream
  typedef enum logic [2:0] {
    KIND_START  = 3'd0,
    KIND_REQ    = 3'd1,
    KIND_TOKEN  = 3'd2,
    KIND_HUNGRY = 3'd3,
    KIND_DONE   = 3'd4
  } kind_e;

  // Node phase
  typedef enum logic [1:0] {
    PH_THINK  = 2'd0,
    PH_HUNGRY = 2'd1,
    PH_EAT    = 2'd2
  } phase_e;

  // Result actions
  typedef enum logic [1:0] {
    ACT_REQ   = 2'd0,
    ACT_TOKEN = 2'd1,
    ACT_EAT   = 2'd2
  } act_e;

  localparam int unsigned MaxResults  = 4;
  localparam int unsigned ResIdxW     = 2;
  localparam int unsigned ResCntW     = 3;
  localparam int unsigned TdataW      = 8;
  localparam int unsigned QueueDepthDef = 2;

  // Register indexes on the config channel
  localparam logic CFG_HOLD_LEFT  = 1'b0;
  localparam logic CFG_HOLD_RIGHT = 1'b1;

  typedef struct packed {
    act_e action;
    logic side;
  } res_t;

  // All results caused by one event
  typedef struct packed {
    logic [ResCntW-1:0]  cnt;
    res_t [MaxResults-1:0] res;
  } pkt_t;

  // Append one result, dropping anything past the fourth
  function automatic pkt_t pkt_push(pkt_t p, act_e a, logic s);
    pkt_t r;
    r = p;
    if (p.cnt < ResCntW'(MaxResults)) begin
      r.res[p.cnt[ResIdxW-1:0]] = '{action: a, side: s};
      r.cnt = p.cnt + ResCntW'(1);
    end
    return r;
  endfunction

endpackage

FILE: hdl/hfen_front.sv
module hfen_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [2:0]        in_kind_i,
  input  logic              in_side_i,
  input  logic              cfg_valid_i,
  input  logic              cfg_index_i,
  input  logic              cfg_data_i,
  output logic              push_o,
  output hfen_pkg::pkt_t    push_pkt_o,
  input  logic              full_i
);
  import hfen_pkg::*;

  typedef struct packed {
    phase_e     phase;
    logic [1:0] hold;
    logic [1:0] clean;
    logic [1:0] sent;
    logic [1:0] pend;
  } node_t;

  typedef struct packed {
    node_t n;
    pkt_t  p;
  } work_t;

  function automatic work_t req_missing(work_t w);
    work_t r;
    r = w;
    for (int i = 0; i < 2; i++) begin
      if (!r.n.hold[i] && !r.n.sent[i]) begin
        r.n.sent[i] = 1'b1;
        r.p = pkt_push(r.p, ACT_REQ, 1'(i));
      end
    end
    return r;
  endfunction

  function automatic work_t hungry_eval(work_t w);
    work_t r;
    logic  gave;
    r = w;
    gave = 1'b0;
    if (r.n.hold[0] && r.n.hold[1]) begin
      r.n.phase = PH_EAT;
      r.p = pkt_push(r.p, ACT_EAT, 1'b0);
    end else begin
      r = req_missing(r);
      for (int i = 0; i < 2; i++) begin
        if (r.n.pend[i] && r.n.hold[i] && !r.n.clean[i]) begin
          r.n.pend[i] = 1'b0;
          r.n.hold[i] = 1'b0;
          r.p = pkt_push(r.p, ACT_TOKEN, 1'(i));
          gave = 1'b1;
        end
      end
      if (gave) begin
        r = req_missing(r);
      end
    end
    return r;
  endfunction

  node_t node_q, node_d;
  logic  hold_l_q, hold_r_q;
  work_t w;
  logic  acc;

  assign in_ready_o = !full_i;
  assign acc = in_valid_i && in_ready_o;

  // Start-up token holdings, to be written only while idle; the block itself does not enforce this
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_l_q <= 1'b0;
      hold_r_q <= 1'b1;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_HOLD_LEFT) begin
        hold_l_q <= cfg_data_i;
      end else begin
        hold_r_q <= cfg_data_i;
      end
    end
  end

  // Classify the event, update bookkeeping, collect results
  always_comb begin
    w = '{n: node_q, p: '0};
    case (kind_e'(in_kind_i))
      KIND_START: begin
        w.n = '{phase: PH_THINK, hold: {hold_r_q, hold_l_q},
                clean: 2'b00, sent: 2'b00, pend: 2'b00};
      end
      KIND_REQ: begin
        if (w.n.phase == PH_EAT) begin
          w.n.pend[in_side_i] = 1'b1;
        end else begin
          if (w.n.hold[in_side_i] && !w.n.clean[in_side_i]) begin
            w.n.hold[in_side_i] = 1'b0;
            w.p = pkt_push(w.p, ACT_TOKEN, in_side_i);
          end else begin
            w.n.pend[in_side_i] = 1'b1;
          end
          if (w.n.phase == PH_HUNGRY) begin
            w = hungry_eval(w);
          end
        end
      end
      KIND_TOKEN: begin
        w.n.hold[in_side_i]  = 1'b1;
        w.n.clean[in_side_i] = 1'b1;
        w.n.sent[in_side_i]  = 1'b0;
        if (w.n.phase == PH_HUNGRY) begin
          w = hungry_eval(w);
        end
      end
      KIND_HUNGRY: begin
        if (w.n.phase == PH_THINK) begin
          w.n.phase = PH_HUNGRY;
          w = hungry_eval(w);
        end
      end
      KIND_DONE: begin
        if (w.n.phase == PH_EAT) begin
          w.n.clean = 2'b00;
          for (int i = 0; i < 2; i++) begin
            if (w.n.pend[i]) begin
              w.n.pend[i] = 1'b0;
              w.n.hold[i] = 1'b0;
              w.p = pkt_push(w.p, ACT_TOKEN, 1'(i));
            end
          end
          w.n.phase = PH_THINK;
        end
      end
      default: ;
    endcase
  end

  assign node_d     = acc ? w.n : node_q;
  assign push_o     = acc && (w.p.cnt != '0);
  assign push_pkt_o = w.p;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_q <= '{phase: PH_THINK, hold: 2'b00, clean: 2'b00, sent: 2'b00, pend: 2'b00};
    end else begin
      node_q <= node_d;
    end
  end

endmodule

FILE: hdl/hfen_queue.sv
module hfen_queue #(
  parameter int unsigned Depth = hfen_pkg::QueueDepthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  hfen_pkg::pkt_t push_pkt_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           avail_o,
  output hfen_pkg::pkt_t pop_pkt_o
);
  import hfen_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  pkt_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign avail_o   = (cnt_q != '0);
  assign pop_pkt_o = mem_q[rptr_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && avail_o;

  // Pointer and fill bookkeeping
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Packet storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_pkt_i;
    end
  end

endmodule

FILE: hdl/hfen_back.sv
module hfen_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           avail_i,
  input  hfen_pkg::pkt_t pkt_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output hfen_pkg::res_t out_res_o,
  output logic           out_last_o
);
  import hfen_pkg::*;

  pkt_t               cur_q, cur_d;
  logic [ResIdxW-1:0] idx_q, idx_d;
  logic               busy_q, busy_d;
  logic               beat;

  assign out_valid_o = busy_q;
  assign out_res_o   = cur_q.res[idx_q];
  assign out_last_o  = ({1'b0, idx_q} == cur_q.cnt - ResCntW'(1));
  assign beat        = busy_q && out_ready_i;

  // Load the next packet when empty or as the last beat leaves
  assign pop_o = avail_i && (!busy_q || (beat && out_last_o));

  always_comb begin
    cur_d  = cur_q;
    idx_d  = idx_q;
    busy_d = busy_q;
    if (pop_o) begin
      cur_d  = pkt_i;
      idx_d  = '0;
      busy_d = 1'b1;
    end else if (beat) begin
      if (out_last_o) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + ResIdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

endmodule

FILE: hdl/hygienic_fork_exchange_node_top.sv
// An accepted event beat is classified combinationally and its result packet is pushed
// into the packet queue; the back end then loads the packet into its output registers.
// Throughput: one event beat per cycle while the packet queue has room; results
// leave at one beat per cycle while m_axis_tready_i is high and packets are queued.
// The output beat rate of the back end sets the sustained rate.
// Reset (rst_ni low, asynchronous): phase thinking, all token bits cleared, queue
// and output empty, holds_left_at_start = 0, holds_right_at_start = 1.
module hygienic_fork_exchange_node_top #(
  parameter int unsigned QueueDepth = hfen_pkg::QueueDepthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [hfen_pkg::TdataW-1:0] s_axis_tdata_i,  // [2:0] kind, [3] side
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [hfen_pkg::TdataW-1:0] m_axis_tdata_o,  // [1:0] action, [2] out_side
  output logic                        m_axis_tlast_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic                        cfg_index_i,
  input  logic                        cfg_data_i
);
  import hfen_pkg::*;

  logic push, full, pop, avail;
  pkt_t push_pkt, pop_pkt;
  res_t res;

  assign cfg_ready_o = 1'b1;

  hfen_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_kind_i   (s_axis_tdata_i[2:0]),
    .in_side_i   (s_axis_tdata_i[3]),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push_o      (push),
    .push_pkt_o  (push_pkt),
    .full_i      (full)
  );

  hfen_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_pkt_i (push_pkt),
    .full_o     (full),
    .pop_i      (pop),
    .avail_o    (avail),
    .pop_pkt_o  (pop_pkt)
  );

  hfen_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .avail_i     (avail),
    .pkt_i       (pop_pkt),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_res_o   (res),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {(TdataW - 3)'(0), res.side, res.action};

endmodule

FILE: hdl/hfen_checker.sv
`include "hygienic_fork_exchange_node_top_macros.svh"

module hfen_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid_i,
  input logic                        s_axis_tready_o,
  input logic [hfen_pkg::TdataW-1:0] s_axis_tdata_i,
  input logic                        m_axis_tvalid_o,
  input logic                        m_axis_tready_i,
  input logic [hfen_pkg::TdataW-1:0] m_axis_tdata_o,
  input logic                        m_axis_tlast_o
);
  import hfen_pkg::*;

  // A stalled result beat holds
  `HFEN_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))

  // Start eating is always the sole result of its event, on the left-side code
  `HFEN_ASSERT(a_eat_alone, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tdata_o[1:0] == ACT_EAT |-> m_axis_tlast_o && !m_axis_tdata_o[2])

  // Only defined actions, padding bits zero
  `HFEN_ASSERT(a_out_code, clk_i, rst_ni, m_axis_tvalid_o |-> m_axis_tdata_o[1:0] != 2'd3 && m_axis_tdata_o[TdataW-1:3] == '0)

  // Nothing leaves in the first cycle after reset
  `HFEN_ASSERT_ALWAYS(a_reset_quiet, clk_i, !$past(rst_ni) |-> !m_axis_tvalid_o)

endmodule

bind hygienic_fork_exchange_node_top hfen_checker u_hfen_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
